// ----- design/uesc_pkg.sv -----
`timescale 1ns / 1ps
package uesc_pkg;
	localparam int MAX_SAMPLES_DEF = 256;
	localparam int MAX_ENVELOPES   = 20;
	localparam int SMP_W           = 12;
	localparam int VAL_W           = 9;
	localparam int ENV_W           = 5;

	localparam logic [VAL_W-1:0] LARGE_LEVEL  = 9'd400;
	localparam int               FIRST_MIN    = 30;
	localparam int               FIRST_MAX    = 55;
	localparam int               NOISE_FIRST  = 11;
	localparam int               NOISE_LAST   = 19;
	localparam int               SIGNAL_FIRST = 20;
	localparam int               WINDOW_LEN   = 10;
	localparam int               LARGE_CLS0   = 50;
	localparam int               LARGE_WIN    = 30;
	localparam int               NOISE_LIM    = 401;
	localparam int               WIN_LIM      = 4010;

	localparam logic [1:0] CLS_NONE    = 2'd0;
	localparam logic [1:0] CLS_SINGLE  = 2'd1;
	localparam logic [1:0] CLS_DOUBLE  = 2'd2;
	localparam logic [1:0] CLS_UNKNOWN = 2'd3;

	localparam logic REG_MARGIN  = 1'b0;
	localparam logic REG_CONFIRM = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_P1,
		ST_P2,
		ST_MUL,
		ST_OUT
	} state_t;
endpackage

// ----- design/uesc_ram.sv -----
`timescale 1ns / 1ps
module uesc_ram #(
	parameter int W = 12,
	parameter int D = 256
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- design/ultrasonic_echo_sheet_classifier_core.sv -----
`timescale 1ns / 1ps
// Sheet classifier for one ultrasonic echo frame. A sample word is taken on start while
// busy is low; the word with frame_end set starts evaluation, and busy then stays high
// through both passes and the multiply and output states: one pass over the sample memory
// smooths and scales in place and gathers statistics, a second pass finds envelopes.
// The result word is shown on done for one cycle only; the receiver cannot stall it.
module ultrasonic_echo_sheet_classifier_core #(
	parameter int MAX_SAMPLES = uesc_pkg::MAX_SAMPLES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [uesc_pkg::SMP_W-1:0]   raw_sample,
	input  logic                         frame_end,
	output logic                         done,
	output logic [1:0]                   frame_class,
	output logic [1:0]                   held_result,
	output logic                         measure_fault,
	output logic [uesc_pkg::VAL_W-1:0]   peak_level,
	output logic [uesc_pkg::ENV_W-1:0]   envelope_count,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_index,
	input  logic [8:0]                   cfg_data
);
	import uesc_pkg::*;

	localparam int AW  = $clog2(MAX_SAMPLES);
	localparam int LW  = AW + 1;
	localparam int SW  = LW + 2;
	localparam int ASW = LW + VAL_W;

	state_t state_q, state_nx;

	logic [8:0]       margin_q;
	logic [3:0]       confirm_q;
	logic [LW-1:0]    wp_q, len_q, ia_q;
	logic [3:0]       rc_none_q, rc_single_q, rc_double_q;
	logic [1:0]       held_q;

	logic             vld_s1, ph_s1, z_s1;
	logic [LW-1:0]    idx_s1;

	logic             mem_we;
	logic [AW-1:0]    mem_waddr, mem_raddr;
	logic [SMP_W-1:0] mem_wdata, mem_rdata;

	logic [SMP_W-1:0] s_hold_q, smprev_q;
	logic [12:0]      noise_sum_q;
	logic [3:0]       noise_cnt_q;
	logic [LW-1:0]    ns_q;
	logic [VAL_W-1:0] ns_val_q, peak_q;
	logic [ASW-1:0]   amp_sum_q, prod_q;
	logic [LW-1:0]    amp_cnt_q, first_q;
	logic [7:0]       large_q;
	logic             first_ok_q;
	logic [SW-1:0]    second_q;

	logic [VAL_W-1:0] tap_q [4];
	logic             falling_q, env_done_q;
	logic [ENV_W-1:0] envs_q;
	logic [13:0]      ws_q;

	logic             accept, last_issue;
	logic [SMP_W-1:0] din, sm;
	logic [12:0]      sm_sum;
	logic [LW-1:0]    j;
	logic [VAL_W-1:0] v;
	logic [9:0]       a0, a1, a2, a3, a4;
	logic [ENV_W-1:0] envs_nx;

	logic             fault, pk_ok, avr2_big, avr2_vld;
	logic [1:0]       cls;

	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	uesc_ram #(.W(SMP_W), .D(MAX_SAMPLES)) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign mem_raddr = ia_q[AW-1:0];
	always_comb begin
		if (state_q == ST_IDLE) begin
			mem_we    = accept && (wp_q < LW'(MAX_SAMPLES));
			mem_waddr = wp_q[AW-1:0];
			mem_wdata = raw_sample;
		end else begin
			mem_we    = vld_s1 && !ph_s1 && (idx_s1 != '0);
			mem_waddr = j[AW-1:0];
			mem_wdata = {{(SMP_W-VAL_W){1'b0}}, v};
		end
	end

	assign last_issue = (state_q == ST_P1) ? (ia_q == len_q) : (ia_q == len_q + LW'(3));

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: if (accept && frame_end) state_nx = ST_P1;
			ST_P1:   if (last_issue) state_nx = ST_P2;
			ST_P2:   if (last_issue) state_nx = ST_MUL;
			ST_MUL:  state_nx = ST_OUT;
			ST_OUT:  state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != ST_IDLE);
		done = (state_q == ST_OUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			margin_q   <= '0;
			confirm_q  <= 4'd3;
			wp_q       <= '0;
			len_q      <= '0;
			ia_q       <= '0;
			vld_s1     <= 1'b0;
			ph_s1      <= 1'b0;
			rc_none_q  <= '0;
			rc_single_q <= '0;
			rc_double_q <= '0;
			held_q     <= CLS_UNKNOWN;
		end else begin
			state_q <= state_nx;
			if (cfg_valid) begin
				if (cfg_index == REG_MARGIN) margin_q <= cfg_data;
				else confirm_q <= cfg_data[3:0];
			end
			vld_s1 <= (state_q == ST_P1) || (state_q == ST_P2);
			ph_s1  <= (state_q == ST_P2);
			if (state_q == ST_IDLE && accept) begin
				if (frame_end) begin
					wp_q  <= '0;
					len_q <= (wp_q < LW'(MAX_SAMPLES)) ? wp_q + LW'(1) : wp_q;
					ia_q  <= '0;
				end else if (wp_q < LW'(MAX_SAMPLES)) begin
					wp_q <= wp_q + LW'(1);
				end
			end else if (state_q == ST_P1 || state_q == ST_P2) begin
				ia_q <= last_issue ? '0 : ia_q + LW'(1);
			end
			if (state_q == ST_OUT) begin
				case (cls)
					CLS_NONE: begin
						rc_single_q <= '0;
						rc_double_q <= '0;
						if ((rc_none_q + 4'(rc_none_q < 4'd15)) >= confirm_q) begin
							rc_none_q <= confirm_q;
							held_q    <= CLS_NONE;
						end else rc_none_q <= rc_none_q + 4'(rc_none_q < 4'd15);
					end
					CLS_SINGLE: begin
						rc_none_q   <= '0;
						rc_double_q <= '0;
						if ((rc_single_q + 4'(rc_single_q < 4'd15)) >= confirm_q) begin
							rc_single_q <= confirm_q;
							held_q      <= CLS_SINGLE;
						end else rc_single_q <= rc_single_q + 4'(rc_single_q < 4'd15);
					end
					default: begin
						rc_none_q   <= '0;
						rc_single_q <= '0;
						if ((rc_double_q + 4'(rc_double_q < 4'd15)) >= confirm_q) begin
							rc_double_q <= confirm_q;
							held_q      <= CLS_DOUBLE;
						end else rc_double_q <= rc_double_q + 4'(rc_double_q < 4'd15);
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= ia_q;
		z_s1   <= (ia_q >= len_q);
	end

	assign din    = z_s1 ? '0 : mem_rdata;
	assign j      = idx_s1 - LW'(1);
	assign sm_sum = {1'b0, din} + {1'b0, smprev_q};
	assign sm     = (idx_s1 == LW'(1)) ? s_hold_q : sm_sum[12:1];
	assign v      = sm[SMP_W-1:3];

	assign a0 = {1'b0, tap_q[0]};
	assign a1 = {1'b0, tap_q[1]};
	assign a2 = {1'b0, tap_q[2]};
	assign a3 = {1'b0, tap_q[3]};
	assign a4 = {1'b0, din[VAL_W-1:0]};
	assign envs_nx = envs_q + ENV_W'(1);

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && frame_end) begin
			noise_sum_q <= '0;
			noise_cnt_q <= '0;
			ns_q        <= '0;
			ns_val_q    <= '0;
			peak_q      <= '0;
			amp_sum_q   <= '0;
			amp_cnt_q   <= '0;
			large_q     <= '0;
			first_ok_q  <= 1'b0;
			first_q     <= '0;
			second_q    <= '0;
			falling_q   <= 1'b0;
			env_done_q  <= 1'b0;
			envs_q      <= '0;
			ws_q        <= '0;
			for (int k = 0; k < 4; k++) tap_q[k] <= '0;
		end else if (vld_s1 && !ph_s1) begin
			if (idx_s1 == '0) begin
				s_hold_q <= din;
			end else begin
				smprev_q <= sm;
				if (j == '0) ns_val_q <= v;
				if (j >= LW'(NOISE_FIRST) && j <= LW'(NOISE_LAST)) begin
					ns_val_q    <= v;
					ns_q        <= j;
					noise_sum_q <= noise_sum_q + 13'(v);
					noise_cnt_q <= noise_cnt_q + 4'd1;
				end
				if (j >= LW'(SIGNAL_FIRST)) begin
					if (!first_ok_q && v > LARGE_LEVEL) begin
						first_ok_q <= 1'b1;
						first_q    <= j;
						second_q   <= SW'(j) + SW'({j, 1'b0});
					end
					if (v > peak_q) peak_q <= v;
					amp_sum_q <= amp_sum_q + ASW'(v);
					amp_cnt_q <= amp_cnt_q + LW'(1);
					if (v > LARGE_LEVEL && large_q != 8'd255) large_q <= large_q + 8'd1;
				end
			end
		end else if (vld_s1 && ph_s1) begin
			tap_q[0] <= tap_q[1];
			tap_q[1] <= tap_q[2];
			tap_q[2] <= tap_q[3];
			tap_q[3] <= din[VAL_W-1:0];
			if (SW'(idx_s1) >= second_q && SW'(idx_s1) < second_q + SW'(WINDOW_LEN))
				ws_q <= ws_q + 14'(din);
			if (idx_s1 >= ns_q + LW'(4) && !env_done_q) begin
				if (!falling_q) begin
					if ((a0 + 10'd5 < a2 && a1 + 10'd5 < a3) || (a2 > a0 + 10'd30))
						falling_q <= 1'b1;
				end else if ((a1 < a0 && a2 < a1 && a3 < a2 && a4 + 10'd10 < a0) ||
						(a3 + 10'd60 < a0)) begin
					envs_q    <= envs_nx;
					falling_q <= 1'b0;
					if (envs_nx >= ENV_W'(MAX_ENVELOPES)) env_done_q <= 1'b1;
				end
			end
		end
		if (state_q == ST_MUL) begin
			prod_q <= (peak_q > margin_q) ?
				(ASW'(peak_q) - ASW'(margin_q)) * ASW'(amp_cnt_q) : '0;
		end
	end

	always_comb begin
		avr2_vld = first_ok_q && (second_q + SW'(WINDOW_LEN) < SW'(len_q));
		avr2_big = avr2_vld && (ws_q >= 14'(WIN_LIM));
		pk_ok    = amp_sum_q < prod_q;
		fault    = ((noise_cnt_q != '0) && (noise_sum_q >= 13'(NOISE_LIM * noise_cnt_q))) ||
			(ns_val_q > LARGE_LEVEL) || !first_ok_q ||
			(first_q > LW'(FIRST_MAX)) || (first_q < LW'(FIRST_MIN));
		if (large_q > 8'(LARGE_CLS0)) cls = CLS_NONE;
		else if (large_q != '0) cls = (large_q > 8'(LARGE_WIN) && avr2_big) ? CLS_NONE : CLS_SINGLE;
		else if (envs_q == '0) cls = CLS_DOUBLE;
		else if (pk_ok) cls = CLS_SINGLE;
		else cls = CLS_DOUBLE;
	end

	always_comb begin
		frame_class    = cls;
		measure_fault  = fault;
		peak_level     = peak_q;
		envelope_count = envs_q;
		case (cls)
			CLS_NONE:   held_result = ((rc_none_q + 4'(rc_none_q < 4'd15)) >= confirm_q) ?
				CLS_NONE : held_q;
			CLS_SINGLE: held_result = ((rc_single_q + 4'(rc_single_q < 4'd15)) >= confirm_q) ?
				CLS_SINGLE : held_q;
			default:    held_result = ((rc_double_q + 4'(rc_double_q < 4'd15)) >= confirm_q) ?
				CLS_DOUBLE : held_q;
		endcase
	end
endmodule
